@@ sv/blinking_lamp_matrix_scanner_unit_macros.svh @@
// ============================================================================
// Assertion macros
// Concurrent assertion helpers used by the lamp scanner back end.
// ============================================================================
`ifndef BLINKING_LAMP_MATRIX_SCANNER_UNIT_MACROS_SVH
`define BLINKING_LAMP_MATRIX_SCANNER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define BLMS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lamp scanner assertion failed");
// Next-cycle implication.
`define BLMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lamp scanner assertion failed");
`else
`define BLMS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define BLMS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ sv/blms_pkg.sv @@
// ============================================================================
// Lamp scanner package
// Types, codes and helper functions of the blinking lamp matrix scanner.
// ============================================================================
package blms_pkg;

    localparam int NUM_LAMPS       = 64;
    localparam int LAMP_W          = $clog2(NUM_LAMPS);
    localparam int QUEUE_DEPTH_DEF = 4;

    // Item opcodes
    localparam logic [1:0] OP_COMMAND = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_SCAN    = 2'd2;
    localparam logic [1:0] OP_SWITCH  = 2'd3;

    // Lamp modes
    localparam logic [1:0] MODE_OFF  = 2'd0;
    localparam logic [1:0] MODE_ON   = 2'd1;
    localparam logic [1:0] MODE_SLOW = 2'd2;
    localparam logic [1:0] MODE_FAST = 2'd3;

    localparam logic [LAMP_W-1:0] DIAG_LAMP = LAMP_W'(22);
    localparam logic [LAMP_W-1:0] LAST_LAMP = LAMP_W'(NUM_LAMPS - 1);

    localparam logic [15:0] DEB_FORCE = 16'hE000;
    localparam logic [15:0] DEB_PRESS = 16'hF000;
    localparam logic [2:0]  DIAG_TOP  = 3'd4;   // above this the count wraps to 0

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] cmd_byte;
        logic       switch_level;
    } request_t;

    typedef struct packed {
        logic [7:0]        lamp_port;
        logic [LAMP_W-1:0] lamp_index;
        logic              diag_led_on;
        logic [2:0]        diag_mode;
        logic              press_seen;
    } result_t;

    // One-hot item class, set by the front end
    typedef struct packed {
        logic cmd;
        logic tick;
        logic scan;
        logic sample;
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [LAMP_W-1:0] lamp;
        logic [1:0]        mode;
        logic              level;
    } qent_t;

    function automatic logic lamp_lit(input logic [1:0] mode, input logic slow,
                                      input logic fast);
        logic lit;
        unique case (mode)
            MODE_ON:   lit = 1'b1;
            MODE_SLOW: lit = slow;
            MODE_FAST: lit = fast;
            default:   lit = 1'b0;
        endcase
        return lit;
    endfunction

    function automatic logic [7:0] drive_code(input logic [LAMP_W-1:0] idx);
        logic [3:0] enable;
        enable = ~(4'b0001 << idx[5:4]);
        return {enable, idx[3:0]};
    endfunction

endpackage

@@ sv/blms_front.sv @@
// ============================================================================
// Lamp scanner front end
// Accept requests, classify them and hold them in a short queue.
// ============================================================================
module blms_front
    import blms_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  request_t request,
    input  logic     take,
    output logic     avail,
    output qent_t    head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    qent_t             q_mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    qent_t             entry;
    logic              push;
    logic              pop;

    // Classify the request
    always_comb
    begin
        entry.kind  = '0;
        entry.lamp  = request.cmd_byte[7:2];
        entry.mode  = request.cmd_byte[1:0];
        entry.level = request.switch_level;
        unique case (request.opcode)
            OP_COMMAND: entry.kind.cmd    = 1'b1;
            OP_TICK:    entry.kind.tick   = 1'b1;
            OP_SCAN:    entry.kind.scan   = 1'b1;
            OP_SWITCH:  entry.kind.sample = 1'b1;
            default:    entry.kind        = '0;
        endcase
    end

    assign busy  = (count_reg == CNT_FULL);
    assign avail = (count_reg != '0);
    assign push  = start && !busy;
    assign pop   = take && avail;
    assign head  = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= entry;
        end
    end

endmodule

@@ sv/blms_back.sv @@
// ============================================================================
// Lamp scanner back end
// Execute queued requests against lamp, blink, scan and debounce state.
// ============================================================================
`include "blinking_lamp_matrix_scanner_unit_macros.svh"

module blms_back
    import blms_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    avail,
    input  qent_t   head,
    output logic    take,
    output logic    done,
    output result_t result
);

    // Lamp mode store; an entry without its valid bit reads as the fill mode
    logic [1:0]           lamp_mem [NUM_LAMPS];
    logic [NUM_LAMPS-1:0] mode_vld_reg, mode_vld_next;
    logic [1:0]           fill_mode_reg, fill_mode_next;
    logic [1:0]           lamp22_reg, lamp22_next;

    logic [1:0]        blink_phase_reg, blink_phase_next;
    logic              slow_reg, slow_next;
    logic              fast_reg, fast_next;
    logic [LAMP_W-1:0] scan_pos_reg, scan_pos_next;
    logic [15:0]       hist_reg, hist_next;
    logic [2:0]        diag_cnt_reg, diag_cnt_next;
    logic              diag_led_reg, diag_led_next;

    // Second stage
    logic              s2_valid_reg;
    logic              s2_scan_reg;
    logic [LAMP_W-1:0] s2_index_reg;
    logic              s2_vld_reg;
    logic [1:0]        s2_fill_reg;
    logic [1:0]        rd_mode_reg;
    logic              s2_slow_reg;
    logic              s2_fast_reg;
    logic              s2_press_reg;

    logic [15:0] hist_shift;
    logic        press;
    logic [2:0]  cnt_step;
    logic [1:0]  all_mode;
    logic [1:0]  shown_mode;

    assign take = avail;

    always_comb
    begin
        hist_shift = {hist_reg[14:0], head.level} | DEB_FORCE;
        press      = take && head.kind.sample && (hist_shift == DEB_PRESS);
        cnt_step   = (diag_cnt_reg > DIAG_TOP) ? 3'd0 : diag_cnt_reg + 3'd1;
        all_mode   = (cnt_step >= 3'd1 && cnt_step <= 3'd3) ? cnt_step[1:0] : MODE_OFF;

        mode_vld_next    = mode_vld_reg;
        fill_mode_next   = fill_mode_reg;
        lamp22_next      = lamp22_reg;
        blink_phase_next = blink_phase_reg;
        slow_next        = slow_reg;
        fast_next        = fast_reg;
        scan_pos_next    = scan_pos_reg;
        hist_next        = hist_reg;
        diag_cnt_next    = diag_cnt_reg;
        diag_led_next    = diag_led_reg;

        if (take)
        begin
            if (head.kind.cmd)
            begin
                mode_vld_next[head.lamp] = 1'b1;
                if (head.lamp == DIAG_LAMP)
                begin
                    lamp22_next = head.mode;
                end
            end
            if (head.kind.tick)
            begin
                slow_next        = blink_phase_reg[1];
                fast_next        = blink_phase_reg[0];
                blink_phase_next = blink_phase_reg + 2'd1;
            end
            if (head.kind.scan)
            begin
                scan_pos_next = scan_pos_reg + 1'b1;
                if (scan_pos_reg == LAST_LAMP)
                begin
                    diag_led_next = lamp_lit(lamp22_reg, slow_reg, fast_reg);
                end
            end
            if (head.kind.sample)
            begin
                hist_next = hist_shift;
            end
            if (press)
            begin
                diag_cnt_next  = cnt_step;
                mode_vld_next  = '0;
                fill_mode_next = all_mode;
                lamp22_next    = all_mode;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_vld_reg    <= '0;
            fill_mode_reg   <= MODE_OFF;
            lamp22_reg      <= MODE_OFF;
            blink_phase_reg <= '0;
            slow_reg        <= 1'b0;
            fast_reg        <= 1'b0;
            scan_pos_reg    <= '0;
            hist_reg        <= '0;
            diag_cnt_reg    <= '0;
            diag_led_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
        end
        else
        begin
            mode_vld_reg    <= mode_vld_next;
            fill_mode_reg   <= fill_mode_next;
            lamp22_reg      <= lamp22_next;
            blink_phase_reg <= blink_phase_next;
            slow_reg        <= slow_next;
            fast_reg        <= fast_next;
            scan_pos_reg    <= scan_pos_next;
            hist_reg        <= hist_next;
            diag_cnt_reg    <= diag_cnt_next;
            diag_led_reg    <= diag_led_next;
            s2_valid_reg    <= take;
        end
    end

    // Store write and registered read
    always_ff @(posedge clk)
    begin
        if (take && head.kind.cmd)
        begin
            lamp_mem[head.lamp] <= head.mode;
        end
        rd_mode_reg <= lamp_mem[scan_pos_reg];
    end

    // Snapshot what the second stage needs
    always_ff @(posedge clk)
    begin
        s2_scan_reg  <= take && head.kind.scan;
        s2_index_reg <= scan_pos_reg;
        s2_vld_reg   <= mode_vld_reg[scan_pos_reg];
        s2_fill_reg  <= fill_mode_reg;
        s2_slow_reg  <= slow_reg;
        s2_fast_reg  <= fast_reg;
        s2_press_reg <= press;
    end

    assign shown_mode = s2_vld_reg ? rd_mode_reg : s2_fill_reg;
    assign done       = s2_valid_reg;

    always_comb
    begin
        result.lamp_port   = (s2_scan_reg && lamp_lit(shown_mode, s2_slow_reg, s2_fast_reg))
                             ? drive_code(s2_index_reg) : 8'd0;
        result.lamp_index  = s2_scan_reg ? s2_index_reg : '0;
        result.diag_led_on = diag_led_reg;
        result.diag_mode   = diag_cnt_reg;
        result.press_seen  = s2_press_reg;
    end

    `BLMS_ASSERT_IMPLY(a_port_matches_index, clk, rst_n, done && result.lamp_port != 8'd0, result.lamp_port[3:0] == result.lamp_index[3:0])
    `BLMS_ASSERT_IMPLY(a_diag_mode_range, clk, rst_n, done, result.diag_mode <= 3'd5)
    `BLMS_ASSERT_NEXT(a_scan_advances, clk, rst_n, take && head.kind.scan, scan_pos_reg == LAMP_W'($past(scan_pos_reg) + 1'b1))

endmodule

@@ sv/blinking_lamp_matrix_scanner_unit.sv @@
// ============================================================================
// Blinking lamp matrix scanner
// Top level: request queue front end plus execution back end.
// ============================================================================
// A request is taken at a rising edge with start high and busy low. Its
// result is strobed on done for one cycle, starting at the next rising edge
// after the accepting edge, in request order. It must be captured at the edge
// that ends that cycle: there is no way to hold it.
// The back end retires one request per cycle, so one request per cycle is
// sustained and busy rises only when the QUEUE_DEPTH-entry queue is full.
// Every request yields exactly one result. Lamp modes live in a 64-entry
// store with a valid bit per entry; a debounced press that re-fills all
// lamps clears the valid bits and loads a fill mode together, so no clearing
// pass is needed after reset.
// ============================================================================
module blinking_lamp_matrix_scanner_unit
    import blms_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  request_t request,
    output logic     done,
    output result_t  result
);

    logic  take;
    logic  avail;
    qent_t head;

    // Accept and classify; hold in the queue
    blms_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .take    (take),
        .avail   (avail),
        .head    (head)
    );

    // Drain one queued request per cycle and strobe its result
    blms_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .avail  (avail),
        .head   (head),
        .take   (take),
        .done   (done),
        .result (result)
    );

endmodule
